// ===== sv/mapc_pkg.sv =====
// Shared types and constants for the moving-average predictive coder.
// No dependencies; the stream interfaces and the top level refer to this package.
`default_nettype none

package mapc_pkg;

    typedef logic signed [7:0] sample_t;

    // configuration register index (byte address bit 2)
    typedef enum logic
    {
        REG_HISTORY_LOG2 = 1'b0,
        REG_DECODE_MODE  = 1'b1
    } reg_idx_t;

    localparam int          APB_ADDR_W        = 3;
    localparam int          APB_DATA_W        = 32;
    localparam int          HIST_LOG2_W       = 3;
    localparam logic [2:0]  HIST_LOG2_RESET   = 3'd2;
    localparam logic        DECODE_MODE_RESET = 1'b0;

endpackage

`default_nettype wire

// ===== sv/mapc_ifs.sv =====
// Valid/ready stream interfaces for the coder's input and result channels.
// Depends on mapc_pkg for the sample type.
`default_nettype none

interface mapc_in_if;
    logic              valid;
    logic              ready;
    mapc_pkg::sample_t sample_in;
    logic              block_start;

    modport source (output valid, output sample_in, output block_start, input ready);
    modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

interface mapc_out_if;
    logic              valid;
    logic              ready;
    mapc_pkg::sample_t value_out;

    modport source (output valid, output value_out, input ready);
    modport sink   (input valid, input value_out, output ready);
endinterface

`default_nettype wire

// ===== sv/moving_average_predictive_coder.sv =====
// Moving-average predictive coder (encode to residuals / decode to samples).
// Depends on mapc_pkg and the stream interfaces in mapc_ifs.sv.
//
// Usage:
//   din  : valid/ready stream of 8-bit signed items plus block_start.
//   dout : valid/ready stream, one 8-bit signed result per input item.
//   APB  : history_log2 at 0x0 (write clears the history), decode_mode at 0x4.
//          Write only while the block is idle.
// Throughput is one item per cycle while dout does not stall. An accepted
// item first passes the read stage, which reads the oldest history entry
// from the ring memory; the compute stage then forms the mean from the
// running sum, produces the result and writes the sample back.
// A read of the slot being written in the same cycle is forwarded.
// The running-sum update is the loop that every item goes through. When dout
// stalls, the result is held in the output register, one more item waits in
// the read stage, and din.ready then drops.
// Reset empties both stages, clears the running sum, fill count and slot
// pointer, and sets history_log2 = 2, decode_mode = 0. The ring memory
// itself is not cleared; warm-up rewrites every slot in use before its value is used.
`default_nettype none

module moving_average_predictive_coder #(
    parameter int MAX_HISTORY = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [mapc_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [mapc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mapc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    mapc_in_if.sink                             din,
    mapc_out_if.source                          dout
);

    // largest usable log2 of the history length
    localparam int KMAX       = $clog2(MAX_HISTORY + 1) - 1;
    localparam int KW         = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
    localparam int AW         = (KMAX > 0) ? KMAX : 1;
    localparam int RING_DEPTH = 1 << KMAX;
    localparam int FW         = $clog2(MAX_HISTORY + 1);
    localparam int SW         = 8 + KMAX;

    // configuration
    logic [mapc_pkg::HIST_LOG2_W-1:0] hist_log2_reg;
    logic [KW-1:0]                    k_reg;
    logic                             decode_reg;
    logic                             cfg_wr;
    mapc_pkg::reg_idx_t               cfg_idx;
    logic [KW-1:0]                    k_wr;

    // read stage
    logic                             s1_valid_reg;
    mapc_pkg::sample_t                s1_sample_reg;
    logic                             s1_start_reg;
    logic [AW-1:0]                    s1_slot_reg;
    mapc_pkg::sample_t                ring_q_reg;
    logic                             byp_hit_reg;
    mapc_pkg::sample_t                byp_data_reg;
    logic [AW-1:0]                    front_slot_reg;
    logic [AW-1:0]                    front_slot_next;
    logic [AW-1:0]                    rd_slot;
    logic [AW-1:0]                    slot_mask;

    // history state
    logic [FW-1:0]                    fill_reg;
    logic [FW-1:0]                    fill_next;
    logic signed [SW-1:0]             sum_reg;
    logic signed [SW-1:0]             sum_next;

    // compute stage
    logic [FW-1:0]                    fill_eff;
    logic signed [SW-1:0]             sum_eff;
    logic [FW-1:0]                    h_val;
    logic                             warm;
    mapc_pkg::sample_t                old_sample;
    logic                             sum_neg;
    logic [SW-1:0]                    sum_mag;
    logic [SW-1:0]                    mag_sh;
    mapc_pkg::sample_t                pred;
    mapc_pkg::sample_t                decoded;
    mapc_pkg::sample_t                residual;
    mapc_pkg::sample_t                new_sample;
    mapc_pkg::sample_t                result;

    // output stage
    logic                             out_valid_reg;
    mapc_pkg::sample_t                out_value_reg;

    logic                             din_fire;
    logic                             advance;

    logic [7:0]                       ring_mem [RING_DEPTH];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = mapc_pkg::reg_idx_t'(paddr[2]);
    assign k_wr    = (pwdata[2:0] > 3'(KMAX)) ? KW'(KMAX) : KW'(pwdata[2:0]);

    always_comb
    begin
        case (cfg_idx)
            mapc_pkg::REG_HISTORY_LOG2:
                prdata = {{(mapc_pkg::APB_DATA_W - mapc_pkg::HIST_LOG2_W){1'b0}},
                          hist_log2_reg};
            mapc_pkg::REG_DECODE_MODE:
                prdata = {{(mapc_pkg::APB_DATA_W - 1){1'b0}}, decode_reg};
            default:
                prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign advance   = s1_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready = !s1_valid_reg || advance;
    assign din_fire  = din.valid && din.ready;

    // ---------------- read stage ----------------
    assign slot_mask       = ~({AW{1'b1}} << k_reg);
    assign rd_slot         = din.block_start ? '0 : front_slot_reg;
    assign front_slot_next = (rd_slot + AW'(1)) & slot_mask;

    // ring memory: one write port (compute stage), one registered read port
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ring_mem[s1_slot_reg] <= new_sample;
        end
        if (din_fire)
        begin
            ring_q_reg    <= ring_mem[rd_slot];
            byp_data_reg  <= new_sample;
            s1_sample_reg <= din.sample_in;
            s1_start_reg  <= din.block_start;
            s1_slot_reg   <= rd_slot;
        end
    end

    // ---------------- compute stage ----------------
    assign fill_eff   = s1_start_reg ? '0 : fill_reg;
    assign sum_eff    = s1_start_reg ? '0 : sum_reg;
    assign h_val      = FW'(1) << k_reg;
    assign warm       = fill_eff < h_val;
    assign old_sample = byp_hit_reg ? byp_data_reg : ring_q_reg;

    // mean truncates toward zero: shift the magnitude, then restore the sign
    assign sum_neg  = sum_eff[SW-1];
    assign sum_mag  = sum_neg ? SW'(-sum_eff) : SW'(sum_eff);
    assign mag_sh   = sum_mag >> k_reg;
    assign pred     = sum_neg ? mapc_pkg::sample_t'(-mag_sh[7:0])
                              : mapc_pkg::sample_t'(mag_sh[7:0]);
    assign decoded  = s1_sample_reg + pred;
    assign residual = s1_sample_reg - pred;

    always_comb
    begin
        if (warm)
        begin
            new_sample = s1_sample_reg;
            result     = s1_sample_reg;
            sum_next   = sum_eff + SW'(s1_sample_reg);
            fill_next  = fill_eff + FW'(1);
        end
        else
        begin
            new_sample = decode_reg ? decoded : s1_sample_reg;
            result     = decode_reg ? decoded : residual;
            sum_next   = sum_eff + SW'(new_sample) - SW'(old_sample);
            fill_next  = fill_eff;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_log2_reg  <= mapc_pkg::HIST_LOG2_RESET;
            k_reg          <= (KMAX < 2) ? KW'(KMAX) : KW'(2);
            decode_reg     <= mapc_pkg::DECODE_MODE_RESET;
            s1_valid_reg   <= 1'b0;
            byp_hit_reg    <= 1'b0;
            front_slot_reg <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (din_fire)
            begin
                s1_valid_reg <= 1'b1;
                // slot written by the compute stage this cycle is read now
                byp_hit_reg  <= advance && (s1_slot_reg == rd_slot);
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr && cfg_idx == mapc_pkg::REG_HISTORY_LOG2)
            begin
                hist_log2_reg  <= pwdata[mapc_pkg::HIST_LOG2_W-1:0];
                k_reg          <= k_wr;
                front_slot_reg <= '0;
                fill_reg       <= '0;
                sum_reg        <= '0;
            end
            else
            begin
                if (din_fire)
                begin
                    front_slot_reg <= front_slot_next;
                end
                if (advance)
                begin
                    fill_reg <= fill_next;
                    sum_reg  <= sum_next;
                end
            end

            if (cfg_wr && cfg_idx == mapc_pkg::REG_DECODE_MODE)
            begin
                decode_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg <= result;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.value_out = out_value_reg;

endmodule

`default_nettype wire

// ===== sv/mapc_checker.sv =====
// Port-level checks for moving_average_predictive_coder, bound to the top level.
// Depends on the top level's clock, reset and stream ports only.
`default_nettype none

module mapc_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       din_valid,
    input wire       din_ready,
    input wire       dout_valid,
    input wire       dout_ready,
    input wire [7:0] dout_value
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid && $stable(dout_value))
        else $error("result changed or dropped while stalled");

    // input backpressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !din_ready |-> dout_valid && !dout_ready)
        else $error("din not ready without output stall");

    // a fresh result follows an accepted item through the read stage and the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dout_valid) |-> $past(din_valid && din_ready, 2))
        else $error("result without a matching accepted item");

endmodule

bind moving_average_predictive_coder mapc_checker u_mapc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .din_valid  (din.valid),
    .din_ready  (din.ready),
    .dout_valid (dout.valid),
    .dout_ready (dout.ready),
    .dout_value (dout.value_out)
);

`default_nettype wire
